/* design/date_text_to_packed_date_macros.svh */
`ifndef DATE_TEXT_TO_PACKED_DATE_MACROS_SVH
`define DATE_TEXT_TO_PACKED_DATE_MACROS_SVH

// condition implies consequence in the same cycle
`define DTPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define DTPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dtpd_pkg.sv */
package dtpd_pkg;

    localparam int CHAR_W = 8;
    localparam int ACC_W  = 12;
    localparam int DATE_W = 19;
    localparam int YEAR_W = 10;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;

    localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_QUERY = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam int ACC_MAX   = 4095;
    localparam int YEAR_MIN  = 1501;
    localparam int YEAR_MAX  = 2500;
    localparam int YEAR_BASE = 1500;
    localparam int MONTH_MAX = 12;
    localparam int DAY_MAX   = 31;

    typedef enum logic [1:0] {
        PHASE_YEAR,
        PHASE_MONTH,
        PHASE_DAY,
        PHASE_DONE
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [DATE_W-1:0] data;
    } result_t;

endpackage

/* design/dtpd_if.sv */
interface dtpd_char_if
    import dtpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface dtpd_date_if
    import dtpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATE_W-1:0] packed_date;

    modport source (output valid, output packed_date, input ready);
    modport sink (input valid, input packed_date, output ready);
endinterface

/* design/date_text_to_packed_date.sv */
// date text to packed date
//
// text channel: one character request per cycle; a zero byte ends the string.
// date channel: one 19-bit packed date per zero byte, year-1500 in bits 18:9,
// month in bits 8:5, day in bits 4:0; an invalid field reads as zero.
//
// a character goes into an input register, then the field parser updates its
// state and builds the packed value in a single pass into the result buffer.
// a zero byte is registered in the input register, then in the result buffer.
// throughput is one character per cycle while the result buffer is not full.
//
// reset clears the field state and empties both buffers; the first string
// starts fresh. the result buffer holds two dates, so a stalled receiver
// stops the text channel only once a second date is waiting.
module date_text_to_packed_date
    import dtpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dtpd_char_if.sink   text,
    dtpd_date_if.source date
);

    logic              char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              full;
    logic              advance;
    logic              take;
    result_t           res;

    assign advance    = char_valid_reg && !full;
    assign text.ready = !char_valid_reg || !full;
    assign take       = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_valid_reg <= 1'b0;
        else
            char_valid_reg <= char_valid_next;
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    always_comb
    begin
        char_next       = take ? text.char_code : char_reg;
        char_valid_next = take ? 1'b1 : (advance ? 1'b0 : char_valid_reg);
    end

    dtpd_field_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (char_reg),
        .res       (res)
    );

    dtpd_out_buffer u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .date  (date),
        .full  (full)
    );

endmodule

/* design/dtpd_field_parser.sv */
module dtpd_field_parser
    import dtpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] char_code,
    output result_t           res
);

    phase_t             phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   year_reg, year_next;
    logic [ACC_W-1:0]   month_reg, month_next;
    logic [ACC_W-1:0]   day_reg, day_next;

    logic               char_numeric;
    logic [3:0]         digit;
    logic [15:0]        acc_wide;
    logic [ACC_W-1:0]   acc_sat;
    logic [ACC_W-1:0]   year_fin, month_fin, day_fin;
    logic [YEAR_W-1:0]  year_field;
    logic [MON_W-1:0]   month_field;
    logic [DAY_W-1:0]   day_field;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_YEAR;
            acc_reg   <= '0;
            year_reg  <= '0;
            month_reg <= '0;
            day_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    // digit classification, '?' reads as zero
    always_comb
    begin
        char_numeric = (char_code == CHAR_QUERY) ||
                       ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE));
        digit    = (char_code == CHAR_QUERY) ? 4'd0 : 4'(char_code - CHAR_ZERO);
        acc_wide = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {12'd0, digit};
        acc_sat  = (acc_wide > 16'(ACC_MAX)) ? ACC_W'(ACC_MAX) : acc_wide[ACC_W-1:0];
    end

    // open field takes the accumulator at end of string
    always_comb
    begin
        year_fin  = (phase_reg == PHASE_YEAR)  ? acc_reg : year_reg;
        month_fin = (phase_reg == PHASE_MONTH) ? acc_reg : month_reg;
        day_fin   = (phase_reg == PHASE_DAY)   ? acc_reg : day_reg;

        if ((year_fin >= ACC_W'(YEAR_MIN)) && (year_fin <= ACC_W'(YEAR_MAX)))
            year_field = YEAR_W'(year_fin - ACC_W'(YEAR_BASE));
        else
            year_field = '0;

        if ((month_fin >= ACC_W'(1)) && (month_fin <= ACC_W'(MONTH_MAX)))
            month_field = month_fin[MON_W-1:0];
        else
            month_field = '0;

        if ((day_fin >= ACC_W'(1)) && (day_fin <= ACC_W'(DAY_MAX)))
            day_field = day_fin[DAY_W-1:0];
        else
            day_field = '0;

        res.data  = {year_field, month_field, day_field};
        res.valid = step && (char_code == CHAR_END);
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;

        if (step)
        begin
            if (char_code == CHAR_END)
            begin
                phase_next = PHASE_YEAR;
                acc_next   = '0;
                year_next  = '0;
                month_next = '0;
                day_next   = '0;
            end
            else if (phase_reg != PHASE_DONE)
            begin
                if (char_numeric)
                    acc_next = acc_sat;
                else
                begin
                    unique case (phase_reg)
                        PHASE_YEAR:
                        begin
                            year_next  = acc_reg;
                            acc_next   = '0;
                            phase_next = PHASE_MONTH;
                        end
                        PHASE_MONTH:
                        begin
                            month_next = acc_reg;
                            acc_next   = '0;
                            phase_next = PHASE_DAY;
                        end
                        PHASE_DAY:
                        begin
                            day_next   = acc_reg;
                            phase_next = PHASE_DONE;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

endmodule

/* design/dtpd_out_buffer.sv */
module dtpd_out_buffer
    import dtpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  result_t           res,
    dtpd_date_if.source       date,
    output logic              full
);

    logic              valid_reg, valid_next;
    logic [DATE_W-1:0] data_reg, data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATE_W-1:0] skid_reg, skid_next;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        skid_reg <= skid_next;
    end

    always_comb
    begin
        pop             = valid_reg && date.ready;
        valid_next      = valid_reg;
        data_next       = data_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            // no new request can arrive while the skid slot is occupied
            if (pop)
            begin
                data_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res.valid)
        begin
            if (!valid_reg || pop)
            begin
                data_next  = res.data;
                valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res.data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            valid_next = 1'b0;
    end

    assign date.valid       = valid_reg;
    assign date.packed_date = data_reg;
    assign full             = skid_valid_reg;

endmodule

/* design/dtpd_checker.sv */
`include "date_text_to_packed_date_macros.svh"

module dtpd_checker
    import dtpd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              text_valid,
    input logic              text_ready,
    input logic              date_valid,
    input logic              date_ready,
    input logic [DATE_W-1:0] packed_date
);

    `DTPD_ASSERT_NEXT(a_date_hold, clk, rst_n, date_valid && !date_ready,
                      date_valid && $stable(packed_date), "stalled date changed")
    `DTPD_ASSERT_SAME(a_year_range, clk, rst_n, date_valid,
                      packed_date[18:9] <= 10'd1000, "year offset out of range")
    `DTPD_ASSERT_SAME(a_month_range, clk, rst_n, date_valid,
                      packed_date[8:5] <= 4'd12, "month out of range")
    `DTPD_ASSERT_NEXT(a_idle_ready, clk, rst_n, !text_valid && !date_valid,
                      text_ready, "text stalled with no date pending")

endmodule

bind date_text_to_packed_date dtpd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_valid  (text.valid),
    .text_ready  (text.ready),
    .date_valid  (date.valid),
    .date_ready  (date.ready),
    .packed_date (date.packed_date)
);
